@@ rtl/jst_pkg.sv @@
package jst_pkg;

   // Parser phases.
   localparam logic [4:0] PH_ELEMENT    = 5'd0;
   localparam logic [4:0] PH_OBJECT     = 5'd1;
   localparam logic [4:0] PH_MEMBER     = 5'd2;
   localparam logic [4:0] PH_COLON      = 5'd3;
   localparam logic [4:0] PH_ARRAY      = 5'd4;
   localparam logic [4:0] PH_ARRAY_ELEM = 5'd5;
   localparam logic [4:0] PH_STR_VAL    = 5'd6;
   localparam logic [4:0] PH_STR_KEY    = 5'd7;
   localparam logic [4:0] PH_ESC_VAL    = 5'd8;
   localparam logic [4:0] PH_ESC_KEY    = 5'd9;
   localparam logic [4:0] PH_HEX_VAL    = 5'd10;
   localparam logic [4:0] PH_HEX_KEY    = 5'd11;
   localparam logic [4:0] PH_LIT_TRUE   = 5'd12;
   localparam logic [4:0] PH_LIT_FALSE  = 5'd13;
   localparam logic [4:0] PH_LIT_NULL   = 5'd14;
   localparam logic [4:0] PH_NUM_MINUS  = 5'd15;
   localparam logic [4:0] PH_NUM_ZERO   = 5'd16;
   localparam logic [4:0] PH_NUM_INT    = 5'd17;
   localparam logic [4:0] PH_FRAC_FIRST = 5'd18;
   localparam logic [4:0] PH_FRAC_DIGITS = 5'd19;
   localparam logic [4:0] PH_EXP_SIGN   = 5'd20;
   localparam logic [4:0] PH_EXP_FIRST  = 5'd21;
   localparam logic [4:0] PH_EXP_DIGITS = 5'd22;
   localparam logic [4:0] PH_AFTER      = 5'd23;

   // Event kinds.
   localparam logic [2:0] EV_BEGIN = 3'd0;
   localparam logic [2:0] EV_END   = 3'd1;
   localparam logic [2:0] EV_KEY   = 3'd2;
   localparam logic [2:0] EV_VALUE = 3'd3;
   localparam logic [2:0] EV_DONE  = 3'd4;
   localparam logic [2:0] EV_ERROR = 3'd5;

   // Node types.
   localparam logic [2:0] NT_OBJECT = 3'd0;
   localparam logic [2:0] NT_ARRAY  = 3'd1;
   localparam logic [2:0] NT_STRING = 3'd2;
   localparam logic [2:0] NT_NUMBER = 3'd3;
   localparam logic [2:0] NT_TRUE   = 3'd4;

   localparam logic [7:0] CH_SPACE = 8'h20;

   // Result queue size; a byte can produce up to two events.
   localparam int OUTQ_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [2:0]  token_class;
      logic [5:0]  token_level;
      logic [15:0] element_index;
      logic [31:0] start_offset;
      logic [31:0] end_offset;
      logic [31:0] node_count;
      logic        last_of_run;
   } event_type;

   // Stack operations requested by one byte.
   typedef struct packed {
      logic push;
      logic push_kind;
      logic pop;
      logic inc;
   } stack_op_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c == CH_SPACE || c == 8'h0A || c == 8'h0D || c == 8'h09;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

endpackage

@@ rtl/jst_step.sv @@
module jst_step #(
   parameter int MAX_DEPTH   = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  logic [4:0]             phase,
   input  logic [2:0]             lit_prog,
   input  logic [5:0]             nest_depth,
   input  logic [31:0]            byte_pos,
   input  logic [31:0]            token_start,
   input  logic [31:0]            nodes_seen,
   input  logic [5:0]             depth_limit,
   input  logic [7:0]             char_byte,
   input  logic                   end_of_doc,
   input  logic                   t_kind,
   input  logic [INDEX_WIDTH-1:0] t_cnt,
   input  logic                   s_kind,
   input  logic [INDEX_WIDTH-1:0] s_cnt,
   output logic [4:0]             phase_in,
   output logic [2:0]             lit_prog_in,
   output logic [5:0]             nest_depth_in,
   output logic [31:0]            byte_pos_in,
   output logic [31:0]            token_start_in,
   output logic [31:0]            nodes_seen_in,
   output jst_pkg::event_type     ev0,
   output jst_pkg::event_type     ev1,
   output logic [1:0]             ev_count,
   output jst_pkg::stack_op_type  op
);
   import jst_pkg::*;

   // Expected character of a literal at a given position.
   function automatic logic [7:0] lit_char(input logic [1:0] li, input logic [2:0] pos);
      logic [7:0] r;
      r = 8'h00;
      case ({li, pos})
         {2'd0, 3'd0}: r = "t";
         {2'd0, 3'd1}: r = "r";
         {2'd0, 3'd2}: r = "u";
         {2'd0, 3'd3}: r = "e";
         {2'd1, 3'd0}: r = "f";
         {2'd1, 3'd1}: r = "a";
         {2'd1, 3'd2}: r = "l";
         {2'd1, 3'd3}: r = "s";
         {2'd1, 3'd4}: r = "e";
         {2'd2, 3'd0}: r = "n";
         {2'd2, 3'd1}: r = "u";
         {2'd2, 3'd2}: r = "l";
         {2'd2, 3'd3}: r = "l";
         default:      r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sat16(input logic [INDEX_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic event_type mk(input logic [2:0] k, input logic [2:0] t,
                                    input logic [5:0] d, input logic [15:0] i,
                                    input logic [31:0] s, input logic [31:0] e,
                                    input logic [31:0] n);
      event_type r;
      r.event_kind    = k;
      r.token_class   = t;
      r.token_level   = d;
      r.element_index = i;
      r.start_offset  = s;
      r.end_offset    = e;
      r.node_count    = n;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   logic                   b_ws;
   logic                   b_dig;
   logic                   inc_need;
   logic [INDEX_WIDTH-1:0] t_cnt_eff;
   logic [15:0]            idx_top;
   logic [15:0]            idx_sec;
   logic [8:0]             lim9;

   // Byte classes; the end flag matches no character.
   assign b_ws  = !end_of_doc && is_ws(char_byte);
   assign b_dig = !end_of_doc && is_digit(char_byte);

   // A new array element bumps the top counter before anything else.
   assign inc_need  = (phase == PH_ARRAY_ELEM) && !b_ws && (nest_depth != 6'd0);
   assign t_cnt_eff = (inc_need && (t_cnt != {INDEX_WIDTH{1'b1}})) ?
                      t_cnt + INDEX_WIDTH'(1) : t_cnt;
   assign idx_top   = (nest_depth != 6'd0 && t_kind) ? sat16(t_cnt_eff) : 16'd0;
   assign idx_sec   = (nest_depth > 6'd1 && s_kind) ? sat16(s_cnt) : 16'd0;
   assign lim9      = (9'(depth_limit) < 9'(MAX_DEPTH)) ? 9'(depth_limit) : 9'(MAX_DEPTH);

   // One full parser step for the accepted byte.
   always_comb begin
      event_type  ev [2];
      event_type  e;
      logic [1:0] n;
      logic       restart;
      logic       run_elem;
      logic       run_after;
      logic       num_end;
      logic       do_close;
      logic       do_fail;
      logic [1:0] li;
      logic [2:0] lp_inc;
      logic [2:0] lit_len;

      ev[0]    = '0;
      ev[1]    = '0;
      e        = '0;
      n        = 2'd0;
      restart  = 1'b0;
      run_elem = 1'b0;
      run_after = 1'b0;
      num_end  = 1'b0;
      do_close = 1'b0;
      do_fail  = 1'b0;
      li       = phase[1:0] - PH_LIT_TRUE[1:0];
      lp_inc   = lit_prog + 3'd1;
      lit_len  = (li == 2'd1) ? 3'd5 : 3'd4;
      op       = '0;
      op.inc   = inc_need;

      phase_in       = phase;
      lit_prog_in    = lit_prog;
      nest_depth_in  = nest_depth;
      token_start_in = token_start;
      nodes_seen_in  = nodes_seen;

      case (phase)
         PH_ELEMENT: begin
            run_elem = 1'b1;
         end
         PH_OBJECT, PH_MEMBER: begin
            if (b_ws) begin
            end else if (!end_of_doc && char_byte == "\"") begin
               token_start_in = byte_pos;
               phase_in       = PH_STR_KEY;
            end else if (!end_of_doc && char_byte == "}" && phase == PH_OBJECT) begin
               do_close = 1'b1;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_COLON: begin
            if (!end_of_doc && char_byte == ":") begin
               phase_in = PH_ELEMENT;
            end else if (!b_ws) begin
               do_fail = 1'b1;
            end
         end
         PH_ARRAY: begin
            if (b_ws) begin
            end else if (!end_of_doc && char_byte == "]") begin
               do_close = 1'b1;
            end else begin
               run_elem = 1'b1;
            end
         end
         PH_ARRAY_ELEM: begin
            if (b_ws) begin
            end else if (nest_depth == 6'd0) begin
               do_fail = 1'b1;
            end else begin
               run_elem = 1'b1;
            end
         end
         PH_STR_VAL, PH_STR_KEY: begin
            if (!end_of_doc && char_byte == "\"") begin
               if (phase == PH_STR_VAL) begin
                  nodes_seen_in = nodes_seen_in + 32'd1;
                  e = mk(EV_VALUE, NT_STRING, nest_depth, idx_top, token_start_in,
                         byte_pos + 32'd1, nodes_seen_in);
                  ev[n[0]] = e;
                  n = n + 2'd1;
                  phase_in = PH_AFTER;
               end else begin
                  e = mk(EV_KEY, NT_STRING, nest_depth, idx_top, token_start_in + 32'd1,
                         byte_pos, nodes_seen_in);
                  ev[n[0]] = e;
                  n = n + 2'd1;
                  phase_in = PH_COLON;
               end
            end else if (!end_of_doc && char_byte == "\\") begin
               phase_in = (phase == PH_STR_VAL) ? PH_ESC_VAL : PH_ESC_KEY;
            end else if (end_of_doc || char_byte < CH_SPACE) begin
               do_fail = 1'b1;
            end
         end
         PH_ESC_VAL, PH_ESC_KEY: begin
            if (!end_of_doc && (char_byte == "\"" || char_byte == "\\" ||
                char_byte == "/" || char_byte == "b" || char_byte == "f" ||
                char_byte == "n" || char_byte == "r" || char_byte == "t")) begin
               phase_in = (phase == PH_ESC_VAL) ? PH_STR_VAL : PH_STR_KEY;
            end else if (!end_of_doc && char_byte == "u") begin
               phase_in    = (phase == PH_ESC_VAL) ? PH_HEX_VAL : PH_HEX_KEY;
               lit_prog_in = 3'd0;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_HEX_VAL, PH_HEX_KEY: begin
            if (end_of_doc || !is_hex(char_byte)) begin
               do_fail = 1'b1;
            end else if (lp_inc >= 3'd4) begin
               lit_prog_in = 3'd0;
               phase_in    = (phase == PH_HEX_VAL) ? PH_STR_VAL : PH_STR_KEY;
            end else begin
               lit_prog_in = lp_inc;
            end
         end
         PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL: begin
            if (lit_prog >= lit_len || end_of_doc || char_byte != lit_char(li, lit_prog)) begin
               do_fail = 1'b1;
            end else if (lp_inc == lit_len) begin
               lit_prog_in   = 3'd0;
               nodes_seen_in = nodes_seen_in + 32'd1;
               e = mk(EV_VALUE, NT_TRUE + 3'(li), nest_depth, idx_top, token_start_in,
                      byte_pos + 32'd1, nodes_seen_in);
               ev[n[0]] = e;
               n = n + 2'd1;
               phase_in = PH_AFTER;
            end else begin
               lit_prog_in = lp_inc;
            end
         end
         PH_NUM_MINUS: begin
            if (!end_of_doc && char_byte == "0") begin
               phase_in = PH_NUM_ZERO;
            end else if (b_dig) begin
               phase_in = PH_NUM_INT;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_NUM_ZERO, PH_NUM_INT: begin
            if (b_dig && phase == PH_NUM_INT) begin
            end else if (!end_of_doc && char_byte == ".") begin
               phase_in = PH_FRAC_FIRST;
            end else if (!end_of_doc && (char_byte == "e" || char_byte == "E")) begin
               phase_in = PH_EXP_SIGN;
            end else begin
               num_end = 1'b1;
            end
         end
         PH_FRAC_FIRST: begin
            if (b_dig) begin
               phase_in = PH_FRAC_DIGITS;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_FRAC_DIGITS: begin
            if (b_dig) begin
            end else if (!end_of_doc && (char_byte == "e" || char_byte == "E")) begin
               phase_in = PH_EXP_SIGN;
            end else begin
               num_end = 1'b1;
            end
         end
         PH_EXP_SIGN: begin
            if (!end_of_doc && (char_byte == "+" || char_byte == "-")) begin
               phase_in = PH_EXP_FIRST;
            end else if (b_dig) begin
               phase_in = PH_EXP_DIGITS;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_EXP_FIRST: begin
            if (b_dig) begin
               phase_in = PH_EXP_DIGITS;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_EXP_DIGITS: begin
            if (!b_dig) begin
               num_end = 1'b1;
            end
         end
         PH_AFTER: begin
            run_after = 1'b1;
         end
         default: begin
            do_fail = 1'b1;
         end
      endcase

      // A number ends on the first byte that cannot extend it; that byte is
      // then handled as the byte after a value.
      if (num_end) begin
         nodes_seen_in = nodes_seen_in + 32'd1;
         e = mk(EV_VALUE, NT_NUMBER, nest_depth, idx_top, token_start_in, byte_pos,
                nodes_seen_in);
         ev[n[0]] = e;
         n = n + 2'd1;
         phase_in  = PH_AFTER;
         run_after = 1'b1;
      end

      // Start of an element.
      if (run_elem) begin
         token_start_in = byte_pos;
         if (b_ws) begin
            phase_in = PH_ELEMENT;
         end else if (!end_of_doc && (char_byte == "{" || char_byte == "[")) begin
            if (9'(nest_depth) + 9'd1 >= lim9) begin
               do_fail = 1'b1;
            end else begin
               nodes_seen_in = nodes_seen_in + 32'd1;
               e = mk(EV_BEGIN, (char_byte == "[") ? NT_ARRAY : NT_OBJECT, nest_depth,
                      idx_top, byte_pos, 32'd0, nodes_seen_in);
               ev[n[0]] = e;
               n = n + 2'd1;
               op.push      = 1'b1;
               op.push_kind = (char_byte == "[");
               nest_depth_in = nest_depth + 6'd1;
               phase_in = (char_byte == "[") ? PH_ARRAY : PH_OBJECT;
            end
         end else if (!end_of_doc && char_byte == "\"") begin
            phase_in = PH_STR_VAL;
         end else if (!end_of_doc && (char_byte == "t" || char_byte == "f" ||
                      char_byte == "n")) begin
            phase_in = (char_byte == "t") ? PH_LIT_TRUE :
                       ((char_byte == "f") ? PH_LIT_FALSE : PH_LIT_NULL);
            lit_prog_in = 3'd1;
         end else if (!end_of_doc && char_byte == "-") begin
            phase_in = PH_NUM_MINUS;
         end else if (!end_of_doc && char_byte == "0") begin
            phase_in = PH_NUM_ZERO;
         end else if (b_dig) begin
            phase_in = PH_NUM_INT;
         end else begin
            do_fail = 1'b1;
         end
      end

      // Byte following a complete value.
      if (run_after && !b_ws) begin
         if (nest_depth == 6'd0) begin
            if (end_of_doc) begin
               e = mk(EV_DONE, NT_OBJECT, 6'd0, 16'd0, 32'd0, byte_pos, nodes_seen_in);
               ev[n[0]] = e;
               n = n + 2'd1;
               restart = 1'b1;
            end else begin
               do_fail = 1'b1;
            end
         end else if (!end_of_doc && char_byte == ",") begin
            phase_in = t_kind ? PH_ARRAY_ELEM : PH_MEMBER;
         end else if (!end_of_doc && char_byte == (t_kind ? 8'h5D : 8'h7D)) begin
            do_close = 1'b1;
         end else begin
            do_fail = 1'b1;
         end
      end

      // Closing bracket of the innermost container.
      if (do_close) begin
         if (nest_depth == 6'd0) begin
            do_fail = 1'b1;
         end else begin
            nest_depth_in = nest_depth - 6'd1;
            e = mk(EV_END, {2'b00, t_kind}, nest_depth - 6'd1, idx_sec, 32'd0,
                   byte_pos + 32'd1, nodes_seen_in);
            ev[n[0]] = e;
            n = n + 2'd1;
            op.pop   = 1'b1;
            phase_in = PH_AFTER;
         end
      end

      // Syntax error ends the document.
      if (do_fail) begin
         e = mk(EV_ERROR, NT_OBJECT, nest_depth, idx_top, byte_pos, 32'd0, nodes_seen_in);
         ev[n[0]] = e;
         n = n + 2'd1;
         restart = 1'b1;
      end

      if (n != 2'd0) begin
         ev[n[0] ^ 1'b1].last_of_run = 1'b1;
      end

      if (restart) begin
         phase_in       = PH_ELEMENT;
         lit_prog_in    = 3'd0;
         nest_depth_in  = 6'd0;
         byte_pos_in    = 32'd0;
         token_start_in = 32'd0;
         nodes_seen_in  = 32'd0;
      end else begin
         byte_pos_in = byte_pos + 32'd1;
      end

      ev0      = ev[0];
      ev1      = ev[1];
      ev_count = n;
   end

endmodule

@@ rtl/jst_stack.sv @@
module jst_stack #(
   parameter int MAX_DEPTH   = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   accept,
   input  jst_pkg::stack_op_type  op,
   input  logic [5:0]             depth,
   output logic                   t_kind,
   output logic [INDEX_WIDTH-1:0] t_cnt,
   output logic                   s_kind,
   output logic [INDEX_WIDTH-1:0] s_cnt
);
   import jst_pkg::*;

   localparam int AW = $clog2(MAX_DEPTH);
   localparam int EW = INDEX_WIDTH + 1;

   // The top two levels live in registers; deeper levels sit in memory, and
   // the entry just below them is always prefetched into rd_ff.
   logic [EW-1:0] mem [MAX_DEPTH];
   logic [EW-1:0] top_ff;
   logic [EW-1:0] top_in;
   logic [EW-1:0] sec_ff;
   logic [EW-1:0] sec_in;
   logic [EW-1:0] rd_ff;
   logic [EW-1:0] top_eff;
   logic [8:0]    wa9;
   logic [8:0]    ra9;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   logic          wr_en;

   assign t_kind = top_ff[EW-1];
   assign t_cnt  = top_ff[INDEX_WIDTH-1:0];
   assign s_kind = sec_ff[EW-1];
   assign s_cnt  = sec_ff[INDEX_WIDTH-1:0];

   // Saturating element count of the top level.
   assign top_eff = (op.inc && (t_cnt != {INDEX_WIDTH{1'b1}})) ?
                    {t_kind, t_cnt + INDEX_WIDTH'(1)} : top_ff;

   // Spill on open, refill on close.
   always_comb begin
      wa9    = 9'(depth) - 9'd2;
      waddr  = wa9[AW-1:0];
      wr_en  = accept && op.push && (depth > 6'd1);
      ra9    = 9'(depth) - 9'd3;
      top_in = top_eff;
      sec_in = sec_ff;
      if (op.push) begin
         top_in = {op.push_kind, {INDEX_WIDTH{1'b0}}};
         sec_in = top_eff;
         ra9    = 9'(depth) - 9'd2;
      end else if (op.pop) begin
         top_in = sec_ff;
         sec_in = rd_ff;
         ra9    = 9'(depth) - 9'd4;
      end
      raddr = ra9[AW-1:0];
   end

   // Memory with registered read and write-through on the same address.
   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff <= top_in;
         sec_ff <= sec_in;
         if (wr_en) begin
            mem[waddr] <= sec_ff;
         end
         if (wr_en && waddr == raddr) begin
            rd_ff <= sec_ff;
         end else begin
            rd_ff <= mem[raddr];
         end
      end
   end

endmodule

@@ rtl/jst_outq.sv @@
module jst_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         wr_count,
   input  jst_pkg::event_type wr_ev0,
   input  jst_pkg::event_type wr_ev1,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output jst_pkg::event_type rsp_ev
);
   import jst_pkg::*;

   localparam int PW = $clog2(OUTQ_DEPTH);
   localparam int CW = $clog2(OUTQ_DEPTH + 1);

   event_type      q_ff [OUTQ_DEPTH];
   logic [PW-1:0]  head_ff;
   logic [PW-1:0]  head_in;
   logic [PW-1:0]  tail_ff;
   logic [PW-1:0]  tail_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_ev    = q_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // A new request needs space for two events.
   assign room      = (count_ff <= CW'(OUTQ_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + PW'(1) : head_ff;
      tail_in  = tail_ff + PW'(wr_count);
      count_in = count_ff + CW'(wr_count) - CW'(pop);
   end

   // Pointer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Event storage.
   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         q_ff[tail_ff] <= wr_ev0;
      end
      if (wr_count == 2'd2) begin
         q_ff[tail_ff + PW'(1)] <= wr_ev1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(OUTQ_DEPTH))
      else $error("result queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && wr_count == 2'd0) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("result queue count wrong after pop");

endmodule

@@ rtl/json_stream_tokenizer.sv @@
// Streaming JSON validator and tokenizer.
// Request channel: one byte of JSON text per request on req_char_byte, or an
// end marker on req_end_of_doc. A request is taken when req_valid is high and
// req_stall is low. Response channel: one event per transfer on the rsp_
// ports, taken when rsp_valid is high and rsp_stall is low; a byte yields zero,
// one or two events, and the last of them carries rsp_last_of_run.
// Each byte is parsed combinationally against the parser state and the two top
// stack levels held in registers; its events are registered into the event
// queue when the request is taken. Throughput is one byte per cycle while the
// event queue has room.
// Events wait in a four-entry queue that drains one event per cycle while
// rsp_stall is low; req_stall rises while fewer than two entries are free, so
// bytes that yield two events are taken only as fast as the queue drains.
// While the receiver stalls, requests keep flowing until three events wait.
// The csr_ channel writes the nesting depth limit and is always ready; write
// it only while the block is idle.
// Reset clears the parser to the start of a document, empties the event queue
// and sets the depth limit to 32. After a done or error event the next byte
// starts a new document at offset zero.
module json_stream_tokenizer #(
   parameter int MAX_DEPTH   = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_doc,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [2:0]  rsp_token_class,
   output logic [5:0]  rsp_token_level,
   output logic [15:0] rsp_element_index,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_end_offset,
   output logic [31:0] rsp_node_count,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_depth_limit
);
   import jst_pkg::*;

   logic [4:0]             phase_ff;
   logic [4:0]             phase_in;
   logic [2:0]             lit_prog_ff;
   logic [2:0]             lit_prog_in;
   logic [5:0]             nest_depth_ff;
   logic [5:0]             nest_depth_in;
   logic [31:0]            byte_pos_ff;
   logic [31:0]            byte_pos_in;
   logic [31:0]            token_start_ff;
   logic [31:0]            token_start_in;
   logic [31:0]            nodes_seen_ff;
   logic [31:0]            nodes_seen_in;
   logic [5:0]             depth_limit_ff;
   logic                   accept;
   logic                   room;
   logic                   t_kind;
   logic [INDEX_WIDTH-1:0] t_cnt;
   logic                   s_kind;
   logic [INDEX_WIDTH-1:0] s_cnt;
   event_type              ev0;
   event_type              ev1;
   event_type              rsp_ev;
   logic [1:0]             ev_count;
   stack_op_type           op;

   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign csr_ready = 1'b1;

   // Parser step.
   jst_step #(
      .MAX_DEPTH   (MAX_DEPTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_step (
      .phase          (phase_ff),
      .lit_prog       (lit_prog_ff),
      .nest_depth     (nest_depth_ff),
      .byte_pos       (byte_pos_ff),
      .token_start    (token_start_ff),
      .nodes_seen     (nodes_seen_ff),
      .depth_limit    (depth_limit_ff),
      .char_byte      (req_char_byte),
      .end_of_doc     (req_end_of_doc),
      .t_kind         (t_kind),
      .t_cnt          (t_cnt),
      .s_kind         (s_kind),
      .s_cnt          (s_cnt),
      .phase_in       (phase_in),
      .lit_prog_in    (lit_prog_in),
      .nest_depth_in  (nest_depth_in),
      .byte_pos_in    (byte_pos_in),
      .token_start_in (token_start_in),
      .nodes_seen_in  (nodes_seen_in),
      .ev0            (ev0),
      .ev1            (ev1),
      .ev_count       (ev_count),
      .op             (op)
   );

   // Container stack.
   jst_stack #(
      .MAX_DEPTH   (MAX_DEPTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_stack (
      .clock  (clock),
      .accept (accept),
      .op     (op),
      .depth  (nest_depth_ff),
      .t_kind (t_kind),
      .t_cnt  (t_cnt),
      .s_kind (s_kind),
      .s_cnt  (s_cnt)
   );

   // Event queue.
   jst_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .wr_count  (accept ? ev_count : 2'd0),
      .wr_ev0    (ev0),
      .wr_ev1    (ev1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_ev    (rsp_ev)
   );

   assign rsp_event_kind    = rsp_ev.event_kind;
   assign rsp_token_class   = rsp_ev.token_class;
   assign rsp_token_level   = rsp_ev.token_level;
   assign rsp_element_index = rsp_ev.element_index;
   assign rsp_start_offset  = rsp_ev.start_offset;
   assign rsp_end_offset    = rsp_ev.end_offset;
   assign rsp_node_count    = rsp_ev.node_count;
   assign rsp_last_of_run   = rsp_ev.last_of_run;

   // Parser state and depth limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_ELEMENT;
         lit_prog_ff    <= 3'd0;
         nest_depth_ff  <= 6'd0;
         byte_pos_ff    <= 32'd0;
         token_start_ff <= 32'd0;
         nodes_seen_ff  <= 32'd0;
         depth_limit_ff <= 6'd32;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            lit_prog_ff    <= lit_prog_in;
            nest_depth_ff  <= nest_depth_in;
            byte_pos_ff    <= byte_pos_in;
            token_start_ff <= token_start_in;
            nodes_seen_ff  <= nodes_seen_in;
         end
         if (csr_valid) begin
            depth_limit_ff <= csr_depth_limit;
         end
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      9'(nest_depth_ff) < 9'(MAX_DEPTH))
      else $error("nesting depth beyond stack size");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_doc) |=>
         (phase_ff == PH_ELEMENT && nest_depth_ff == 6'd0 && byte_pos_ff == 32'd0))
      else $error("end marker did not close the document");

   a_events_need_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !room) |=> $stable(byte_pos_ff))
      else $error("request taken without queue space");

endmodule
